// ----- src/lav_pkg.sv -----
// shared types and helpers for the look-at view matrix block
package lav_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;

    typedef struct packed {
        logic signed [COORD_W-1:0] camera_x;
        logic signed [COORD_W-1:0] camera_y;
        logic signed [COORD_W-1:0] camera_z;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
        logic signed [COORD_W-1:0] up_x;
        logic signed [COORD_W-1:0] up_y;
        logic signed [COORD_W-1:0] up_z;
    } in_req_t;

    typedef struct packed {
        logic [1:0]                row_index;
        logic signed [COORD_W-1:0] col0;
        logic signed [COORD_W-1:0] col1;
        logic signed [COORD_W-1:0] col2;
        logic signed [COORD_W-1:0] col3;
        logic                      degenerate;
        logic                      last_row;
    } out_row_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] cam;
        logic [2:0][DIFF_W-1:0]  dir;
        logic [2:0][COORD_W-1:0] up;
    } job_t;

    typedef struct packed {
        logic go;
        logic done;
        logic ok;
    } norm_ctl_t;

    localparam logic [1:0] LAST_ROW = 2'd3;

    function automatic logic [1:0] next3(input logic [1:0] g);
        case (g)
            2'd0:    next3 = 2'd1;
            2'd1:    next3 = 2'd2;
            default: next3 = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] prev3(input logic [1:0] g);
        case (g)
            2'd0:    prev3 = 2'd2;
            2'd1:    prev3 = 2'd0;
            default: prev3 = 2'd1;
        endcase
    endfunction

endpackage

// ----- src/lav_front.sv -----
// request intake: forms the view direction and queues requests for the engine
module lav_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lav_pkg::in_req_t req,
    input  logic             pop,
    output logic             avail,
    output lav_pkg::job_t    job
);

    lav_pkg::job_t job_reg [2];
    lav_pkg::job_t job_in;
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push;

    assign busy  = (count_reg == 2'd2);
    assign avail = (count_reg != 2'd0);
    assign push  = start && !busy;
    assign job   = job_reg[rd_ptr_reg];

    always_comb
    begin
        job_in.cam[0] = req.camera_x;
        job_in.cam[1] = req.camera_y;
        job_in.cam[2] = req.camera_z;
        job_in.up[0]  = req.up_x;
        job_in.up[1]  = req.up_y;
        job_in.up[2]  = req.up_z;
        job_in.dir[0] = 33'($signed({req.target_x[31], req.target_x})
                          - $signed({req.camera_x[31], req.camera_x}));
        job_in.dir[1] = 33'($signed({req.target_y[31], req.target_y})
                          - $signed({req.camera_y[31], req.camera_y}));
        job_in.dir[2] = 33'($signed({req.target_z[31], req.target_z})
                          - $signed({req.camera_z[31], req.camera_z}));
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_reg[wr_ptr_reg] <= job_in;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> avail)
        else $error("pop from empty queue");

endmodule

// ----- src/lav_norm.sv -----
// vector normalize unit: shift alignment, sum of squares, serial sqrt and divide
module lav_norm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [2:0][63:0]       vec,
    output lav_pkg::norm_ctl_t     stat,
    output logic [2:0][31:0]       unit
);

    localparam int NUM_W = 31 + FRAC_BITS;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_MAG   = 6'b000010,
        N_SHIFT = 6'b000100,
        N_SQ    = 6'b001000,
        N_SQRT  = 6'b010000,
        N_DIV   = 6'b100000
    } nstate_t;

    nstate_t               state_reg, state_next;
    logic [63:0]           mag_reg [3];
    logic [2:0]            neg_reg;
    logic [59:0]           prod_reg;
    logic [63:0]           x_reg, res_reg, bit_reg;
    logic [30:0]           len_reg;
    logic [1:0]            idx_reg;
    logic                  load_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [31:0]           rem_reg;
    logic [FRAC_BITS:0]    numlo_reg, q_reg;
    logic [2:0][31:0]      unit_reg;
    logic                  ok_reg, done_reg;

    logic [63:0]           mx, mab, trial;
    logic [29:0]           sq_op, div_m;
    logic [NUM_W-1:0]      num;
    logic [32:0]           rem_sh;
    logic                  qbit;
    logic [FRAC_BITS:0]    q_next;
    logic [63:0]           res_next;

    assign stat.go   = go;
    assign stat.done = done_reg;
    assign stat.ok   = ok_reg;
    assign unit      = unit_reg;

    always_comb
    begin
        mab = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        mx  = (mab > mag_reg[2]) ? mab : mag_reg[2];
        sq_op = (idx_reg == 2'd3) ? 30'd0 : mag_reg[idx_reg][29:0];
        div_m = (idx_reg == 2'd3) ? 30'd0 : mag_reg[idx_reg][29:0];
        num = NUM_W'({div_m, {FRAC_BITS{1'b0}}}) + NUM_W'(len_reg >> 1);
        trial = res_reg + bit_reg;
        res_next = (x_reg >= trial) ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
        rem_sh = {rem_reg, numlo_reg[FRAC_BITS]};
        qbit   = (rem_sh >= {2'b00, len_reg});
        q_next = {q_reg[FRAC_BITS-1:0], qbit};
        state_next = state_reg;
        case (state_reg)
            N_IDLE:  if (go) state_next = N_MAG;
            N_MAG:   state_next = (mx == 64'd0) ? N_IDLE : N_SHIFT;
            N_SHIFT: if ((|mx[63:30]) == 1'b0 && mx[29]) state_next = N_SQ;
            N_SQ:    if (idx_reg == 2'd3) state_next = N_SQRT;
            N_SQRT:  if (bit_reg == 64'd1) state_next = N_DIV;
            N_DIV:   if (!load_reg && cnt_reg == CNT_LAST && idx_reg == 2'd2)
                         state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == N_MAG && mx == 64'd0)
            begin
                done_reg <= 1'b1;
                ok_reg   <= 1'b0;
            end
            else if (state_reg == N_DIV && state_next == N_IDLE)
            begin
                done_reg <= 1'b1;
                ok_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= vec[i][63];
                    mag_reg[i] <= vec[i][63] ? (64'd0 - vec[i]) : vec[i];
                end
            end
            N_MAG:
            begin
                idx_reg <= 2'd0;
                if (mx == 64'd0)
                begin
                    unit_reg <= '0;
                end
            end
            N_SHIFT:
            begin
                if (|mx[63:30])
                begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (!mx[29])
                begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            N_SQ:
            begin
                prod_reg <= sq_op * sq_op;
                x_reg    <= (idx_reg == 2'd0) ? 64'd0 : x_reg + 64'(prod_reg);
                idx_reg  <= idx_reg + 2'd1;
                res_reg  <= 64'd0;
                bit_reg  <= 64'd1 << 62;
                load_reg <= 1'b1;
            end
            N_SQRT:
            begin
                if (x_reg >= trial) x_reg <= x_reg - trial;
                res_reg <= res_next;
                bit_reg <= bit_reg >> 2;
                len_reg <= res_next[30:0];
                idx_reg <= 2'd0;
            end
            N_DIV:
            begin
                if (load_reg)
                begin
                    rem_reg   <= 32'(num >> (FRAC_BITS + 1));
                    numlo_reg <= num[FRAC_BITS:0];
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    load_reg  <= 1'b0;
                end
                else
                begin
                    rem_reg   <= qbit ? 32'(rem_sh - {2'b00, len_reg}) : rem_sh[31:0];
                    numlo_reg <= {numlo_reg[FRAC_BITS-1:0], 1'b0};
                    q_reg     <= q_next;
                    cnt_reg   <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST)
                    begin
                        unit_reg[idx_reg] <= neg_reg[idx_reg] ? (32'd0 - 32'(q_next))
                                                              : 32'(q_next);
                        idx_reg  <= idx_reg + 2'd1;
                        load_reg <= 1'b1;
                    end
                end
            end
            default:
            begin
                idx_reg <= 2'd0;
            end
        endcase
    end

    a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !ok_reg |-> unit_reg == '0)
        else $error("degenerate vector gave nonzero unit");

endmodule

// ----- src/lav_back.sv -----
// matrix engine: forward and right normalize, cross products, translation, row output
module lav_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              avail,
    input  lav_pkg::job_t     job,
    output logic              pop,
    output logic              res_valid,
    output lav_pkg::out_row_t res
);

    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
    localparam logic [31:0] ONE  = 32'd1 << FRAC_BITS;

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_NF    = 7'b0000010,
        B_CROSS = 7'b0000100,
        B_NR    = 7'b0001000,
        B_UPV   = 7'b0010000,
        B_TRANS = 7'b0100000,
        B_EMIT  = 7'b1000000
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic [2:0][31:0]     cam_reg, up_reg, fwd_reg, rgt_reg, upv_reg, tr_reg;
    logic [2:0][32:0]     dir_reg;
    logic [2:0][63:0]     cr_reg;
    logic                 okf_reg, okr_reg;
    logic                 go_reg;
    logic                 iss_reg;
    logic [1:0]           ig_reg, ip_reg;
    logic                 av_reg, alast_reg, asub_reg;
    logic [1:0]           ag_reg, ap_reg;
    logic signed [65:0]   prod_reg;
    logic signed [63:0]   acc_reg, acc_next;
    logic [1:0]           row_reg;
    logic                 res_valid_reg;
    lav_pkg::out_row_t    res_reg, row_out;

    logic [2:0][63:0]     norm_vec;
    lav_pkg::norm_ctl_t   nstat;
    logic [2:0][31:0]     nunit;
    logic [31:0]          va, vb;
    logic signed [32:0]   opa, opb;
    logic [1:0]           glast;
    logic                 mac_on, grp_end;
    logic [1:0]           n1, n2;

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + HALF) >> FRAC_BITS;
        rnd = v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [31:0] sat(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat = 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            sat = 32'h8000_0000;
        else
            sat = v[31:0];
    endfunction

    lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (go_reg),
        .vec  (norm_vec),
        .stat (nstat),
        .unit (nunit)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            norm_vec[i] = (state_reg == B_NF) ? 64'($signed(dir_reg[i])) : cr_reg[i];
        end
    end

    assign pop = (state_reg == B_IDLE) && avail;
    assign mac_on = (state_reg == B_CROSS) || (state_reg == B_UPV) || (state_reg == B_TRANS);
    assign glast = (state_reg == B_TRANS) ? 2'd2 : 2'd1;
    assign grp_end = av_reg && alast_reg && (ag_reg == 2'd2);
    assign n1 = lav_pkg::next3(ig_reg);
    assign n2 = lav_pkg::prev3(ig_reg);

    always_comb
    begin
        va = '0;
        vb = '0;
        case (state_reg)
            B_CROSS:
            begin
                va = (ip_reg == 2'd0) ? up_reg[n1] : up_reg[n2];
                vb = (ip_reg == 2'd0) ? fwd_reg[n2] : fwd_reg[n1];
            end
            B_UPV:
            begin
                va = (ip_reg == 2'd0) ? fwd_reg[n1] : fwd_reg[n2];
                vb = (ip_reg == 2'd0) ? rgt_reg[n2] : rgt_reg[n1];
            end
            B_TRANS:
            begin
                case (ig_reg)
                    2'd0:    va = rgt_reg[ip_reg];
                    2'd1:    va = upv_reg[ip_reg];
                    default: va = fwd_reg[ip_reg];
                endcase
                vb = cam_reg[ip_reg];
            end
            default:
            begin
                va = '0;
                vb = '0;
            end
        endcase
        opa = $signed({va[31], va});
        opb = $signed({vb[31], vb});
        acc_next = asub_reg ? ((ap_reg == 2'd0) ? 64'sd0 : acc_reg) - prod_reg[63:0]
                            : ((ap_reg == 2'd0) ? 64'sd0 : acc_reg) + prod_reg[63:0];
    end

    always_comb
    begin
        row_out.row_index  = row_reg;
        row_out.degenerate = !okf_reg || !okr_reg;
        row_out.last_row   = (row_reg == lav_pkg::LAST_ROW);
        if (row_reg == lav_pkg::LAST_ROW)
        begin
            row_out.col0 = tr_reg[0];
            row_out.col1 = tr_reg[1];
            row_out.col2 = tr_reg[2];
            row_out.col3 = ONE;
        end
        else
        begin
            row_out.col0 = rgt_reg[row_reg];
            row_out.col1 = upv_reg[row_reg];
            row_out.col2 = fwd_reg[row_reg];
            row_out.col3 = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (avail) state_next = B_NF;
            B_NF:    if (nstat.done) state_next = B_CROSS;
            B_CROSS: if (grp_end) state_next = B_NR;
            B_NR:    if (nstat.done) state_next = B_UPV;
            B_UPV:   if (grp_end) state_next = B_TRANS;
            B_TRANS: if (grp_end) state_next = B_EMIT;
            B_EMIT:  if (row_reg == lav_pkg::LAST_ROW) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            go_reg        <= 1'b0;
            iss_reg       <= 1'b0;
            av_reg        <= 1'b0;
            row_reg       <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= (state_reg == B_IDLE && avail)
                          || (state_reg == B_CROSS && grp_end);
            res_valid_reg <= (state_reg == B_EMIT);
            av_reg        <= mac_on && iss_reg;
            if ((state_reg == B_NF || state_reg == B_NR) && nstat.done)
            begin
                iss_reg <= 1'b1;
            end
            else if (grp_end && state_reg == B_UPV)
            begin
                iss_reg <= 1'b1;
            end
            else if (mac_on && iss_reg && ip_reg == glast && ig_reg == 2'd2)
            begin
                iss_reg <= 1'b0;
            end
            if (state_reg == B_EMIT)
            begin
                row_reg <= row_reg + 2'd1;
            end
            else
            begin
                row_reg <= 2'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cam_reg <= job.cam;
            dir_reg <= job.dir;
            up_reg  <= job.up;
        end
        if (state_reg == B_NF && nstat.done)
        begin
            fwd_reg <= nunit;
            okf_reg <= nstat.ok;
        end
        if (state_reg == B_NR && nstat.done)
        begin
            rgt_reg <= nunit;
            okr_reg <= nstat.ok;
        end
        if (!(mac_on && iss_reg))
        begin
            ig_reg <= 2'd0;
            ip_reg <= 2'd0;
        end
        else
        begin
            prod_reg  <= opa * opb;
            ag_reg    <= ig_reg;
            ap_reg    <= ip_reg;
            alast_reg <= (ip_reg == glast);
            asub_reg  <= (state_reg != B_TRANS) && (ip_reg == 2'd1);
            if (ip_reg == glast)
            begin
                ip_reg <= 2'd0;
                ig_reg <= ig_reg + 2'd1;
            end
            else
            begin
                ip_reg <= ip_reg + 2'd1;
            end
        end
        if (av_reg)
        begin
            acc_reg <= acc_next;
            if (alast_reg)
            begin
                case (state_reg)
                    B_CROSS: cr_reg[ag_reg]  <= acc_next;
                    B_UPV:   upv_reg[ag_reg] <= 32'(rnd(acc_next));
                    B_TRANS: tr_reg[ag_reg]  <= sat(-rnd(acc_next));
                    default: ;
                endcase
            end
        end
        if (state_reg == B_EMIT)
        begin
            res_reg <= row_out;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_rows_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.last_row |=>
            res_valid_reg && res_reg.row_index == 2'($past(res_reg.row_index) + 2'd1))
        else $error("matrix rows not consecutive");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.last_row == (res_reg.row_index == lav_pkg::LAST_ROW)))
        else $error("last row flag mismatch");

endmodule

// ----- src/look_at_view_matrix.sv -----
// look-at view matrix top level: request queue in front of the matrix engine
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  request  | start, busy          | req  (camera, target, up)
//  result   | res_valid (strobe)   | res  (one matrix row a cycle)
//
// the engine's work on a request takes in the alignment shifts of the two normalize passes
// and the bit-serial square root and divider; a zero-length vector skips them
// the four rows leave on consecutive cycles
// a two-entry queue takes new requests while the engine works; busy is high
// only while that queue is full
// reset clears the queue and engine control; no clearing pass is needed
// results cannot be held off by the receiver
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lav_pkg::in_req_t  req,
    output logic              res_valid,
    output lav_pkg::out_row_t res
);

    logic          pop;
    logic          avail;
    lav_pkg::job_t job;

    lav_front u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .pop  (pop),
        .avail(avail),
        .job  (job)
    );

    lav_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .avail    (avail),
        .job      (job),
        .pop      (pop),
        .res_valid(res_valid),
        .res      (res)
    );

endmodule

// ----- sim/look_at_view_matrix_tb.sv -----
// testbench for the look-at view matrix block: directed and random requests checked row by row
module look_at_view_matrix_tb;

    localparam int FB = 16;
    localparam int WATCH_LIMIT = 20000;
    localparam int TAIL_CYCLES = 400;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    lav_pkg::in_req_t  req = '0;
    logic              res_valid;
    lav_pkg::out_row_t res;

    lav_pkg::in_req_t  pending_reqs[$];
    lav_pkg::out_row_t expected_rows[$];
    int                fail_count = 0;
    int                idle_cycles = 0;
    int                send_idle_pct = 34;

    look_at_view_matrix #(.FRAC_BITS(FB)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .res_valid(res_valid), .res(res)
    );

    always #6 clk = ~clk;

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_fb(input longint v);
        longint m;
        m = (mag(v) + (longint'(1) << (FB - 1))) >>> FB;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit unit_vec(input longint v[3], output longint u[3]);
        longint unsigned m[3], mx, sum, len, q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = mag(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        for (int i = 0; i < 3; i++) u[i] = 0;
        if (mx == 0) return 1'b0;
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    task automatic predict_view_rows(input lav_pkg::in_req_t r);
        longint cam[3], dir[3], upw[3], fwd[3], crs[3], rgt[3], upv[3], tr[3];
        longint ent[4][4];
        bit ok_f, ok_r;
        lav_pkg::out_row_t row;
        cam = '{longint'(r.camera_x), longint'(r.camera_y), longint'(r.camera_z)};
        dir = '{longint'(r.target_x) - cam[0], longint'(r.target_y) - cam[1],
                longint'(r.target_z) - cam[2]};
        upw = '{longint'(r.up_x), longint'(r.up_y), longint'(r.up_z)};
        ok_f = unit_vec(dir, fwd);
        crs[0] = upw[1] * fwd[2] - upw[2] * fwd[1];
        crs[1] = upw[2] * fwd[0] - upw[0] * fwd[2];
        crs[2] = upw[0] * fwd[1] - upw[1] * fwd[0];
        ok_r = unit_vec(crs, rgt);
        upv[0] = round_fb(fwd[1] * rgt[2] - fwd[2] * rgt[1]);
        upv[1] = round_fb(fwd[2] * rgt[0] - fwd[0] * rgt[2]);
        upv[2] = round_fb(fwd[0] * rgt[1] - fwd[1] * rgt[0]);
        tr[0] = clamp32(-round_fb(rgt[0] * cam[0] + rgt[1] * cam[1] + rgt[2] * cam[2]));
        tr[1] = clamp32(-round_fb(upv[0] * cam[0] + upv[1] * cam[1] + upv[2] * cam[2]));
        tr[2] = clamp32(-round_fb(fwd[0] * cam[0] + fwd[1] * cam[1] + fwd[2] * cam[2]));
        for (int i = 0; i < 3; i++) ent[i] = '{rgt[i], upv[i], fwd[i], 0};
        ent[3] = '{tr[0], tr[1], tr[2], longint'(1) << FB};
        for (int k = 0; k < 4; k++)
        begin
            row.row_index  = 2'(k);
            row.col0       = ent[k][0][31:0];
            row.col1       = ent[k][1][31:0];
            row.col2       = ent[k][2][31:0];
            row.col3       = ent[k][3][31:0];
            row.degenerate = !ok_f || !ok_r;
            row.last_row   = (2'(k) == lav_pkg::LAST_ROW);
            expected_rows.push_back(row);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            2: return 32'($signed($urandom_range(0, 255)) - 128);
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
        endcase
    endfunction

    function automatic lav_pkg::in_req_t make_req(input logic [31:0] c[3],
                                                  input logic [31:0] t[3],
                                                  input logic [31:0] u[3]);
        lav_pkg::in_req_t r;
        r = '{c[0], c[1], c[2], t[0], t[1], t[2], u[0], u[1], u[2]};
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            predict_view_rows(req);
            void'(pending_reqs.pop_front());
        end
        if (pending_reqs.size() > 0)
        begin
            if (start && busy)
                start <= 1'b1;
            else if ($urandom_range(0, 99) < send_idle_pct)
                start <= 1'b0;
            else
            begin
                start <= 1'b1;
                req <= pending_reqs[0];
            end
        end
        else
            start <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        lav_pkg::out_row_t want;
        if (rst_n && res_valid)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("unexpected row %0d", res.row_index);
                fail_count++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (res.row_index !== want.row_index)
                begin
                    $error("row_index exp %0d got %0d", want.row_index, res.row_index);
                    fail_count++;
                end
                if (res.col0 !== want.col0)
                begin
                    $error("col0 exp %0d got %0d", want.col0, res.col0);
                    fail_count++;
                end
                if (res.col1 !== want.col1)
                begin
                    $error("col1 exp %0d got %0d", want.col1, res.col1);
                    fail_count++;
                end
                if (res.col2 !== want.col2)
                begin
                    $error("col2 exp %0d got %0d", want.col2, res.col2);
                    fail_count++;
                end
                if (res.col3 !== want.col3)
                begin
                    $error("col3 exp %0d got %0d", want.col3, res.col3);
                    fail_count++;
                end
                if (res.degenerate !== want.degenerate)
                begin
                    $error("degenerate exp %0d got %0d", want.degenerate, res.degenerate);
                    fail_count++;
                end
                if (res.last_row !== want.last_row)
                begin
                    $error("last_row exp %0d got %0d", want.last_row, res.last_row);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || res_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] c[3], t[3], u[3];
        logic [31:0] one;
        one = 32'h0001_0000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // directed: identity view, degenerate forward, up parallel to forward, extremes
        c = '{0, 0, 0};            t = '{0, 0, one};          u = '{0, one, 0};
        pending_reqs.push_back(make_req(c, t, u));
        c = '{one, 2 * one, 3 * one}; t = c;                   u = '{0, one, 0};
        pending_reqs.push_back(make_req(c, t, u));
        c = '{0, 0, 0};            t = '{0, 5 * one, 0};      u = '{0, one, 0};
        pending_reqs.push_back(make_req(c, t, u));
        c = '{5, 5, 5};            t = '{5, 5, 5};            u = '{0, 0, 0};
        pending_reqs.push_back(make_req(c, t, u));
        c = '{32'h80000000, 32'h80000000, 32'h80000000};
        t = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        u = '{32'h80000000, 32'h7fffffff, 32'h80000000};
        pending_reqs.push_back(make_req(c, t, u));
        c = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
        t = '{32'h80000000, 32'h7fffffff, 32'h80000000};
        u = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        pending_reqs.push_back(make_req(c, t, u));
        c = '{32'h7fff0000, 32'h80010000, 32'h7fff0000}; t = '{0, 0, 0}; u = '{0, one, 0};
        pending_reqs.push_back(make_req(c, t, u));
        c = '{0, 0, 0}; t = '{1, 0, 0};   u = '{0, 0, 1};
        pending_reqs.push_back(make_req(c, t, u));
        c = '{0, 0, 0}; t = '{0, 0, -1};  u = '{32'hffffffff, 32'hffffffff, 32'hffffffff};
        pending_reqs.push_back(make_req(c, t, u));
        c = '{32'hffffffff, 0, 0}; t = '{32'h7fffffff, 0, 0}; u = '{0, one, 0};
        pending_reqs.push_back(make_req(c, t, u));
        for (int n = 0; n < 100; n++)
        begin
            if (n == 35) send_idle_pct = 79;
            if (n == 70) send_idle_pct = 0;
            for (int i = 0; i < 3; i++)
            begin
                c[i] = rand_coord();
                t[i] = rand_coord();
                u[i] = rand_coord();
            end
            if ($urandom_range(0, 19) == 0) t = c;
            if ($urandom_range(0, 19) == 0) u = '{0, 0, 0};
            while (pending_reqs.size() > 4) @(posedge clk);
            pending_reqs.push_back(make_req(c, t, u));
        end
        while (pending_reqs.size() > 0 || start) @(posedge clk);
        while (expected_rows.size() > 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
